@@ hdl/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and helpers of the chunked transfer deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  localparam int SIZE_BITS_DEFAULT = 32;
  localparam int HEX_DIGIT_BITS    = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_EXT,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_LAST_CR,
    PH_LAST_LF,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SIZE = 2'd1,
    ERR_CRLF = 2'd2
  } err_t;

  typedef struct packed {
    logic       is_payload;
    logic       msg_end;
    logic [1:0] status;
  } flags_t;

  // {digit valid, digit value}
  function automatic logic [HEX_DIGIT_BITS:0] hex_decode(input logic [7:0] c);
    logic [HEX_DIGIT_BITS:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/chd_in_reg.sv @@
// ----------------------------------------------------------------------------
// chd_in_reg
// Input register: holds one byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       s_take,
  output logic            s_valid,
  output logic [7:0]      s_byte
);

  assign in_ready = !s_valid || s_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

@@ hdl/chd_step.sv @@
// ----------------------------------------------------------------------------
// chd_step
// Framing decode for one byte: next parser state and the flags of the byte.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_step #(
  parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
  input  wire chd_pkg::phase_t  phase,
  input  wire logic [SIZE_BITS-1:0] remaining_count,
  input  wire logic             digit_seen,
  input  wire chd_pkg::err_t    error_code,
  input  wire logic [7:0]       in_byte,
  output chd_pkg::phase_t       phase_next,
  output logic [SIZE_BITS-1:0]  remaining_count_next,
  output logic                  digit_seen_next,
  output chd_pkg::err_t         error_code_next,
  output chd_pkg::flags_t       flags
);

  logic [chd_pkg::HEX_DIGIT_BITS:0] hex;

  assign hex = chd_pkg::hex_decode(in_byte);

  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    digit_seen_next      = digit_seen;
    error_code_next      = error_code;
    case (phase)
      chd_pkg::PH_SIZE: begin
        if (hex[chd_pkg::HEX_DIGIT_BITS]) begin
          // top digit must be free or the size no longer fits
          if (remaining_count[SIZE_BITS-1 -: chd_pkg::HEX_DIGIT_BITS] != '0) begin
            phase_next      = chd_pkg::PH_ERROR;
            error_code_next = chd_pkg::ERR_SIZE;
          end else begin
            remaining_count_next = {remaining_count[SIZE_BITS-chd_pkg::HEX_DIGIT_BITS-1:0],
                                    hex[chd_pkg::HEX_DIGIT_BITS-1:0]};
            digit_seen_next      = 1'b1;
          end
        end else if (!digit_seen) begin
          phase_next      = chd_pkg::PH_ERROR;
          error_code_next = chd_pkg::ERR_SIZE;
        end else if (in_byte == chd_pkg::CH_CR) begin
          phase_next = chd_pkg::PH_SIZE_LF;
        end else begin
          phase_next = chd_pkg::PH_EXT;
        end
      end
      chd_pkg::PH_EXT: begin
        if (in_byte == chd_pkg::CH_CR) begin
          phase_next = chd_pkg::PH_SIZE_LF;
        end
      end
      chd_pkg::PH_SIZE_LF: begin
        if (in_byte != chd_pkg::CH_LF) begin
          phase_next      = chd_pkg::PH_ERROR;
          error_code_next = chd_pkg::ERR_SIZE;
        end else begin
          digit_seen_next = 1'b0;
          phase_next      = (remaining_count == '0) ? chd_pkg::PH_LAST_CR : chd_pkg::PH_DATA;
        end
      end
      chd_pkg::PH_DATA: begin
        remaining_count_next = remaining_count - 1'b1;
        if (remaining_count == SIZE_BITS'(1)) begin
          phase_next = chd_pkg::PH_DATA_CR;
        end
      end
      chd_pkg::PH_DATA_CR: begin
        if (in_byte == chd_pkg::CH_CR) begin
          phase_next = chd_pkg::PH_DATA_LF;
        end else begin
          phase_next      = chd_pkg::PH_ERROR;
          error_code_next = chd_pkg::ERR_CRLF;
        end
      end
      chd_pkg::PH_DATA_LF: begin
        if (in_byte == chd_pkg::CH_LF) begin
          phase_next           = chd_pkg::PH_SIZE;
          remaining_count_next = '0;
        end else begin
          phase_next      = chd_pkg::PH_ERROR;
          error_code_next = chd_pkg::ERR_CRLF;
        end
      end
      chd_pkg::PH_LAST_CR: begin
        if (in_byte == chd_pkg::CH_CR) begin
          phase_next = chd_pkg::PH_LAST_LF;
        end else begin
          phase_next      = chd_pkg::PH_ERROR;
          error_code_next = chd_pkg::ERR_CRLF;
        end
      end
      chd_pkg::PH_LAST_LF: begin
        if (in_byte == chd_pkg::CH_LF) begin
          phase_next           = chd_pkg::PH_SIZE;
          remaining_count_next = '0;
        end else begin
          phase_next      = chd_pkg::PH_ERROR;
          error_code_next = chd_pkg::ERR_CRLF;
        end
      end
      default: begin
        // error phase is sticky
        phase_next = chd_pkg::PH_ERROR;
        if (error_code == chd_pkg::ERR_NONE) begin
          error_code_next = chd_pkg::ERR_SIZE;
        end
      end
    endcase
  end

  always_comb begin
    flags.is_payload = (phase == chd_pkg::PH_DATA);
    flags.msg_end    = (phase == chd_pkg::PH_LAST_LF) && (in_byte == chd_pkg::CH_LF);
    flags.status     = error_code_next;
  end

endmodule

`default_nettype wire

@@ hdl/chd_out_reg.sv @@
// ----------------------------------------------------------------------------
// chd_out_reg
// Result register: holds one decoded byte and its flags for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic [7:0]      load_byte,
  input  wire chd_pkg::flags_t load_flags,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output chd_pkg::flags_t      out_flags
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      out_byte  <= load_byte;
      out_flags <= load_flags;
    end
  end

endmodule

`default_nettype wire

@@ hdl/chunked_transfer_deframer.sv @@
// ----------------------------------------------------------------------------
// chunked_transfer_deframer
// Decodes the framing of a chunked message body, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_byte) takes the encoded body one byte
//   per item. out channel (out_valid/out_ready) returns every byte unchanged
//   in out_byte, with is_payload set on chunk data, msg_end on the LF that
//   closes the message, and status 0 ok, 1 bad size line, 2 missing CRLF.
//   An accepted byte passes the input register, then the parser state update
//   feeding the result register, which raises out_valid.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   parser state (phase, size count, error code) is updated once per byte.
//   Reset clears the parser to expect the first size digit of a new message,
//   clears the error code and empties both registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_ready drops; nothing is lost or repeated.
//   After an error every byte is echoed with its status until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_transfer_deframer #(
  parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            is_payload,
  output logic            msg_end,
  output logic [1:0]      status
);

  logic                 s_valid;
  logic [7:0]           s_byte;
  logic                 s_take;
  logic                 free;

  chd_pkg::phase_t      phase;
  chd_pkg::phase_t      phase_next;
  logic [SIZE_BITS-1:0] remaining_count;
  logic [SIZE_BITS-1:0] remaining_count_next;
  logic                 digit_seen;
  logic                 digit_seen_next;
  chd_pkg::err_t        error_code;
  chd_pkg::err_t        error_code_next;
  chd_pkg::flags_t      step_flags;
  chd_pkg::flags_t      out_flags;

  assign s_take = s_valid && free;

  chd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .s_take   (s_take),
    .s_valid  (s_valid),
    .s_byte   (s_byte)
  );

  chd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .phase                (phase),
    .remaining_count      (remaining_count),
    .digit_seen           (digit_seen),
    .error_code           (error_code),
    .in_byte              (s_byte),
    .phase_next           (phase_next),
    .remaining_count_next (remaining_count_next),
    .digit_seen_next      (digit_seen_next),
    .error_code_next      (error_code_next),
    .flags                (step_flags)
  );

  // parser state advances only when a byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= chd_pkg::PH_SIZE;
      remaining_count <= '0;
      digit_seen      <= 1'b0;
      error_code      <= chd_pkg::ERR_NONE;
    end else if (s_take) begin
      phase           <= phase_next;
      remaining_count <= remaining_count_next;
      digit_seen      <= digit_seen_next;
      error_code      <= error_code_next;
    end
  end

  chd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (s_valid),
    .load_byte  (s_byte),
    .load_flags (step_flags),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_flags  (out_flags)
  );

  assign is_payload = out_flags.is_payload;
  assign msg_end    = out_flags.msg_end;
  assign status     = out_flags.status;

endmodule

`default_nettype wire

@@ hdl/chd_checker.sv @@
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks of the chunked transfer deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       is_payload,
  input wire logic       msg_end,
  input wire logic [1:0] status
);

  // an error byte is never payload and never closes a message
  a_err_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != chd_pkg::ERR_NONE) |-> !is_payload && !msg_end)
    else $error("error byte carries payload or end flag");

  // the message always closes on an LF framing byte
  a_end_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_end |-> (out_byte == chd_pkg::CH_LF) && !is_payload)
    else $error("msg_end on a byte that is not a framing LF");

  // errors are sticky until reset
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != chd_pkg::ERR_NONE) |=> status == $past(status))
    else $error("error status changed before reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
    else $error("stalled result changed");

endmodule

bind chunked_transfer_deframer chd_checker u_chd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .is_payload (is_payload),
  .msg_end    (msg_end),
  .status     (status)
);

`default_nettype wire
